// File: rtl/tppd_pkg.sv
// package: pixel format codes, channel widening tables and sizes for the tile pixel decoder
`timescale 1ns / 1ps

package tppd_pkg;

   localparam int PAL_DEPTH_DEFAULT = 256;
   localparam int COLOR_W           = 15;
   localparam int BYTE_W            = 8;
   localparam int SLOT_W            = 3;
   localparam int CHAN_W            = 8;

   localparam logic [2:0] FMT_1BPP      = 3'd3;
   localparam logic [2:0] FMT_2BPP      = 3'd4;
   localparam logic [2:0] FMT_4BPP      = 3'd5;
   localparam logic [2:0] FMT_8BPP_PAL  = 3'd6;
   localparam logic [2:0] FMT_RGB332    = 3'd7;
   localparam logic [2:0] FMT_RESET     = FMT_8BPP_PAL;

   localparam logic       MODE_PAL_WRITE = 1'b0;
   localparam logic       MODE_DECODE    = 1'b1;

   localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'd0;
   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd255;

   typedef logic [COLOR_W-1:0] color_type;

   // floor(c * 255 / 31)
   function automatic logic [CHAN_W-1:0] widen5(input logic [4:0] c);
      logic [CHAN_W-1:0] r;
      begin
         case (c)
            5'd0:  r = 8'd0;
            5'd1:  r = 8'd8;
            5'd2:  r = 8'd16;
            5'd3:  r = 8'd24;
            5'd4:  r = 8'd32;
            5'd5:  r = 8'd41;
            5'd6:  r = 8'd49;
            5'd7:  r = 8'd57;
            5'd8:  r = 8'd65;
            5'd9:  r = 8'd74;
            5'd10: r = 8'd82;
            5'd11: r = 8'd90;
            5'd12: r = 8'd98;
            5'd13: r = 8'd106;
            5'd14: r = 8'd115;
            5'd15: r = 8'd123;
            5'd16: r = 8'd131;
            5'd17: r = 8'd139;
            5'd18: r = 8'd148;
            5'd19: r = 8'd156;
            5'd20: r = 8'd164;
            5'd21: r = 8'd172;
            5'd22: r = 8'd180;
            5'd23: r = 8'd189;
            5'd24: r = 8'd197;
            5'd25: r = 8'd205;
            5'd26: r = 8'd213;
            5'd27: r = 8'd222;
            5'd28: r = 8'd230;
            5'd29: r = 8'd238;
            5'd30: r = 8'd246;
            default: r = 8'd255;
         endcase
         return r;
      end
   endfunction

   // floor(c * 255 / 7)
   function automatic logic [CHAN_W-1:0] widen3(input logic [2:0] c);
      logic [CHAN_W-1:0] r;
      begin
         case (c)
            3'd0: r = 8'd0;
            3'd1: r = 8'd36;
            3'd2: r = 8'd72;
            3'd3: r = 8'd109;
            3'd4: r = 8'd145;
            3'd5: r = 8'd182;
            3'd6: r = 8'd218;
            default: r = 8'd255;
         endcase
         return r;
      end
   endfunction

   // floor(c * 255 / 3)
   function automatic logic [CHAN_W-1:0] widen2(input logic [1:0] c);
      logic [CHAN_W-1:0] r;
      begin
         case (c)
            2'd0: r = 8'd0;
            2'd1: r = 8'd85;
            2'd2: r = 8'd170;
            default: r = 8'd255;
         endcase
         return r;
      end
   endfunction

endpackage

// File: rtl/tile_pixel_palette_decoder_unit.sv
// Tile pixel palette decoder: unpacks one tile byte per beat into 1 to 8 pixels, looks
// them up in a 256-entry RGB555 palette (or widens RGB332) and emits one pixel per cycle
// while the output is not stalled. A decode beat yields 8, 4, 2 or 1 pixels for 1, 2, 4
// and 8 bits per pixel, the unpack register issuing one palette read per pixel on the single
// read port; a palette write beat and a beat under an invalid format issue no read. The
// first pixel passes from the unpack register through the lookup stage into the output
// register, and a new byte is taken in the cycle its predecessor issues its last pixel. The
// palette reads as zero after reset through one valid bit per entry, so there is no clearing
// pass. pixel_format is sampled live and should be changed only while the block is empty.
`timescale 1ns / 1ps

module tile_pixel_palette_decoder_unit
   import tppd_pkg::*;
#(
   parameter int PALETTE_DEPTH = PAL_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                csr_wr_en,
   input  logic [2:0]          csr_wr_data,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_mode,
   input  logic [BYTE_W-1:0]   req_data_byte,
   input  logic [BYTE_W-1:0]   req_palette_index,
   input  logic [COLOR_W-1:0]  req_palette_color,
   input  logic                req_transparent,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [CHAN_W-1:0]   rsp_red,
   output logic [CHAN_W-1:0]   rsp_green,
   output logic [CHAN_W-1:0]   rsp_blue,
   output logic [CHAN_W-1:0]   rsp_alpha,
   output logic [SLOT_W-1:0]   rsp_pixel_slot,
   output logic                rsp_last
);

   localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam logic [BYTE_W:0] DEPTH_LIM = (BYTE_W + 1)'(PALETTE_DEPTH);

   // configuration
   logic [2:0] csr_pixel_format_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_pixel_format_ff <= FMT_RESET;
      end else if (csr_wr_en) begin
         csr_pixel_format_ff <= csr_wr_data;
      end
   end

   // unpack stage
   logic               s0_valid_ff, s0_valid_in;
   logic               s0_mode_ff;
   logic [BYTE_W-1:0]  s0_data_ff;
   logic [BYTE_W-1:0]  s0_index_ff;
   color_type          s0_color_ff;
   logic               s0_transp_ff;
   logic [SLOT_W-1:0]  s0_slot_ff, s0_slot_in;

   // lookup stage
   logic               s1_valid_ff;
   logic [BYTE_W-1:0]  s1_value_ff;
   logic               s1_hit_ff;
   logic               s1_rgb332_ff;
   logic               s1_transp_ff;
   logic [SLOT_W-1:0]  s1_slot_ff;
   logic               s1_last_ff;
   color_type          rd_data_ff;

   // output register
   logic               rsp_valid_ff;
   logic [CHAN_W-1:0]  rsp_red_ff, rsp_green_ff, rsp_blue_ff, rsp_alpha_ff;
   logic [SLOT_W-1:0]  rsp_slot_ff;
   logic               rsp_last_ff;

   // palette
   color_type              pal_mem [PALETTE_DEPTH];
   logic [PALETTE_DEPTH-1:0] pal_valid_ff;

   logic               adv2, adv1;
   logic               fmt_ok, pix_last;
   logic [BYTE_W-1:0]  pix_value;
   logic               pixel_emit, write_en, wr_in_range, rd_in_range;
   logic               s0_done, req_accept;
   logic [AW-1:0]      wr_addr, rd_addr;
   color_type          s1_color;

   assign adv2 = !rsp_valid_ff || !rsp_stall;
   assign adv1 = !s1_valid_ff || adv2;

   // pixel select for the current slot
   always_comb begin
      fmt_ok    = 1'b1;
      pix_last  = 1'b1;
      pix_value = '0;
      unique case (csr_pixel_format_ff) inside
         FMT_1BPP: begin
            pix_value = {7'd0, s0_data_ff[s0_slot_ff]};
            pix_last  = (s0_slot_ff == 3'd7);
         end
         FMT_2BPP: begin
            pix_value = {6'd0, s0_data_ff[{s0_slot_ff[1:0], 1'b0} +: 2]};
            pix_last  = (s0_slot_ff[1:0] == 2'd3);
         end
         FMT_4BPP: begin
            pix_value = {4'd0, s0_data_ff[{s0_slot_ff[0], 2'b00} +: 4]};
            pix_last  = s0_slot_ff[0];
         end
         FMT_8BPP_PAL, FMT_RGB332: begin
            pix_value = s0_data_ff;
            pix_last  = 1'b1;
         end
         default: begin
            fmt_ok = 1'b0;
         end
      endcase
   end

   assign write_en    = s0_valid_ff && (s0_mode_ff == MODE_PAL_WRITE);
   assign pixel_emit  = s0_valid_ff && (s0_mode_ff == MODE_DECODE) && fmt_ok && adv1;
   assign s0_done     = s0_valid_ff && ((s0_mode_ff == MODE_PAL_WRITE) || !fmt_ok ||
                                        (adv1 && pix_last));
   assign req_stall   = s0_valid_ff && !s0_done;
   assign req_accept  = req_valid && !req_stall;

   assign wr_in_range = ({1'b0, s0_index_ff} < DEPTH_LIM);
   assign rd_in_range = ({1'b0, pix_value} < DEPTH_LIM);
   assign wr_addr     = s0_index_ff[AW-1:0];
   assign rd_addr     = pix_value[AW-1:0];

   always_comb begin
      s0_valid_in = s0_valid_ff;
      s0_slot_in  = s0_slot_ff;
      if (req_accept) begin
         s0_valid_in = 1'b1;
         s0_slot_in  = '0;
      end else if (s0_done) begin
         s0_valid_in = 1'b0;
      end else if (pixel_emit) begin
         s0_slot_in  = s0_slot_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s0_slot_ff  <= '0;
      end else begin
         s0_valid_ff <= s0_valid_in;
         s0_slot_ff  <= s0_slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s0_mode_ff   <= req_mode;
         s0_data_ff   <= req_data_byte;
         s0_index_ff  <= req_palette_index;
         s0_color_ff  <= req_palette_color;
         s0_transp_ff <= req_transparent;
      end
   end

   // palette storage, one write port and one registered read port
   always_ff @(posedge clock) begin
      if (write_en && wr_in_range) begin
         pal_mem[wr_addr] <= s0_color_ff;
      end
      if (pixel_emit) begin
         rd_data_ff <= pal_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pal_valid_ff <= '0;
      end else if (write_en && wr_in_range) begin
         pal_valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv1) begin
         s1_valid_ff <= pixel_emit;
      end
   end

   always_ff @(posedge clock) begin
      if (pixel_emit) begin
         s1_value_ff  <= pix_value;
         s1_hit_ff    <= rd_in_range && pal_valid_ff[rd_addr];
         s1_rgb332_ff <= (csr_pixel_format_ff == FMT_RGB332);
         s1_transp_ff <= s0_transp_ff;
         s1_slot_ff   <= s0_slot_ff;
         s1_last_ff   <= pix_last;
      end
   end

   // widening into the output register
   assign s1_color = s1_hit_ff ? rd_data_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv2) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2 && s1_valid_ff) begin
         if (s1_rgb332_ff) begin
            rsp_red_ff   <= widen3(s1_value_ff[7:5]);
            rsp_green_ff <= widen3(s1_value_ff[4:2]);
            rsp_blue_ff  <= widen2(s1_value_ff[1:0]);
         end else begin
            rsp_red_ff   <= widen5(s1_color[14:10]);
            rsp_green_ff <= widen5(s1_color[9:5]);
            rsp_blue_ff  <= widen5(s1_color[4:0]);
         end
         rsp_alpha_ff <= (s1_transp_ff && (s1_value_ff == '0)) ? ALPHA_CLEAR : ALPHA_OPAQUE;
         rsp_slot_ff  <= s1_slot_ff;
         rsp_last_ff  <= s1_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red        = rsp_red_ff;
   assign rsp_green      = rsp_green_ff;
   assign rsp_blue       = rsp_blue_ff;
   assign rsp_alpha      = rsp_alpha_ff;
   assign rsp_pixel_slot = rsp_slot_ff;
   assign rsp_last       = rsp_last_ff;

   // checks
   a_accept_frees_unpack: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> (!s0_valid_ff || s0_done))
      else $error("beat accepted while unpack stage still busy");

   a_palette_cleared: assert property (@(posedge clock)
      reset |=> (pal_valid_ff == '0))
      else $error("palette valid bits not cleared by reset");

   a_pixels_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |=> rsp_valid_ff)
      else $error("gap between pixels of one byte");

   a_slot_steps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && !rsp_last_ff) |=>
         (rsp_slot_ff == $past(rsp_slot_ff) + 3'd1))
      else $error("pixel slot did not advance by one");

endmodule
